@@ hdl/keyed_byte_substitution_unit_defines.svh @@
// Assertion macros for the keyed byte substitution unit checks
`ifndef KEYED_BYTE_SUBSTITUTION_UNIT_DEFINES_SVH
`define KEYED_BYTE_SUBSTITUTION_UNIT_DEFINES_SVH

// same-cycle implication
`define KBS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("kbs check failed");

// next-cycle implication
`define KBS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("kbs check failed");

`endif

@@ hdl/kbs_pkg.sv @@
// Types and constants shared by the keyed byte substitution unit
package kbs_pkg;

	localparam logic [31:0] KEY_MULT = 32'h1A74_3125;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_KEY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SEED     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_XOR_KEY  = 2'd2;

	localparam logic REQ_BUILD  = 1'b0;
	localparam logic REQ_DECODE = 1'b1;

	typedef struct packed {
		logic       en;
		logic [7:0] addr_a;
		logic [7:0] addr_b;
	} tab_rd_t;

	typedef struct packed {
		logic       en;
		logic [7:0] addr;
		logic [7:0] data;
	} tab_wr_t;

endpackage

@@ hdl/kbs_tab.sv @@
// Substitution table: 256x8 memory, two registered read ports, one write port
module kbs_tab (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fill,
	input  kbs_pkg::tab_rd_t rd,
	input  kbs_pkg::tab_wr_t wr,
	output logic [7:0]      data_a,
	output logic [7:0]      data_b
);
	import kbs_pkg::*;

	logic [7:0]   mem [256];
	logic [255:0] vld_q;
	logic         ident_q;

	logic [7:0] rd_a_s1, rd_b_s1, idx_a_s1, idx_b_s1;
	logic       vld_a_s1, vld_b_s1, ident_s1;

	// unwritten entries read as zero after reset, as their index after a fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			ident_q <= 1'b0;
		end else if (fill) begin
			vld_q   <= '0;
			ident_q <= 1'b1;
		end else if (wr.en) begin
			vld_q[wr.addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_a_s1  <= mem[rd.addr_a];
			rd_b_s1  <= mem[rd.addr_b];
			vld_a_s1 <= vld_q[rd.addr_a];
			vld_b_s1 <= vld_q[rd.addr_b];
			idx_a_s1 <= rd.addr_a;
			idx_b_s1 <= rd.addr_b;
			ident_s1 <= ident_q;
		end
	end

	assign data_a = vld_a_s1 ? rd_a_s1 : (ident_s1 ? idx_a_s1 : 8'h00);
	assign data_b = vld_b_s1 ? rd_b_s1 : (ident_s1 ? idx_b_s1 : 8'h00);

endmodule

@@ hdl/keyed_byte_substitution_unit.sv @@
// Keyed byte substitution unit: table build sequencer and byte decoder
// Decode: result strobed in the cycle after accept; one decode word per cycle while not busy.
// Build: result strobed as busy falls. Each round is two swaps, each of which
// reads both entries, then writes one and then the other, on the table's
// single write port.
// Reset: registers clear, table reads as all zeros until the first build.
module keyed_byte_substitution_unit #(
	parameter int ROUNDS = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [kbs_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [31:0]                  cfg_data,
	input  logic                         start,
	output logic                         busy,
	input  logic                         req_type,
	input  logic [7:0]                   in_byte,
	input  logic                         last_in,
	output logic                         done,
	output logic [7:0]                   out_byte,
	output logic [31:0]                  final_key,
	output logic                         last_out
);
	import kbs_pkg::*;

	localparam int RW = $clog2(ROUNDS + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD1,
		ST_WA1,
		ST_WB1,
		ST_RD2,
		ST_WA2,
		ST_WB2
	} state_t;

	state_t        state_q;
	logic [RW-1:0] cnt_q;
	logic [31:0]   init_key_q, seed_q, key_q, prod_q, fin_q;
	logic [7:0]    xor_key_q;
	logic          done_q, dec_q, last_q;

	tab_rd_t    rd;
	tab_wr_t    wr;
	logic       fill;
	logic [7:0] data_a, data_b;
	logic       acc_dec, acc_bld;
	logic [31:0] rot;

	assign busy    = (state_q != ST_IDLE);
	assign acc_dec = start && !busy && (req_type == REQ_DECODE);
	assign acc_bld = start && !busy && (req_type == REQ_BUILD);
	assign fill    = acc_bld;
	assign rot     = {key_q[1:0], key_q[31:2]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_key_q <= '0;
			seed_q     <= '0;
			xor_key_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_INIT_KEY: init_key_q <= cfg_data;
				CFG_SEED:     seed_q     <= cfg_data;
				CFG_XOR_KEY:  xor_key_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		rd = '0;
		wr = '0;
		case (state_q)
			ST_IDLE: begin
				rd.en     = acc_dec;
				rd.addr_a = xor_key_q ^ in_byte;
				rd.addr_b = xor_key_q ^ in_byte;
			end
			ST_RD1: begin
				rd.en     = 1'b1;
				rd.addr_a = key_q[23:16];
				rd.addr_b = key_q[7:0];
			end
			ST_WA1: begin
				wr.en   = 1'b1;
				wr.addr = key_q[23:16];
				wr.data = data_b;
			end
			ST_WB1: begin
				wr.en   = 1'b1;
				wr.addr = key_q[7:0];
				wr.data = data_a;
			end
			ST_RD2: begin
				rd.en     = 1'b1;
				rd.addr_a = key_q[15:8];
				rd.addr_b = key_q[31:24];
			end
			ST_WA2: begin
				wr.en   = 1'b1;
				wr.addr = key_q[15:8];
				wr.data = data_b;
			end
			ST_WB2: begin
				wr.en   = 1'b1;
				wr.addr = key_q[31:24];
				wr.data = data_a;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
			dec_q   <= 1'b0;
			last_q  <= 1'b0;
			key_q   <= '0;
			prod_q  <= '0;
			fin_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (acc_dec) begin
						done_q <= 1'b1;
						dec_q  <= 1'b1;
						last_q <= last_in;
					end else if (acc_bld) begin
						key_q   <= init_key_q;
						cnt_q   <= '0;
						state_q <= ST_RD1;
					end
				end
				ST_RD1: begin
					prod_q  <= rot * KEY_MULT;
					state_q <= ST_WA1;
				end
				ST_WA1: state_q <= ST_WB1;
				ST_WB1: state_q <= ST_RD2;
				ST_RD2: state_q <= ST_WA2;
				ST_WA2: state_q <= ST_WB2;
				ST_WB2: begin
					key_q <= seed_q + prod_q;
					if (cnt_q == RW'(ROUNDS - 1)) begin
						fin_q   <= seed_q + prod_q;
						done_q  <= 1'b1;
						dec_q   <= 1'b0;
						last_q  <= 1'b0;
						state_q <= ST_IDLE;
					end else begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= ST_RD1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	kbs_tab u_tab (
		.clk    (clk),
		.arst_n (arst_n),
		.fill   (fill),
		.rd     (rd),
		.wr     (wr),
		.data_a (data_a),
		.data_b (data_b)
	);

	assign done      = done_q;
	assign out_byte  = dec_q ? data_a : 8'h00;
	assign final_key = dec_q ? 32'h0 : fin_q;
	assign last_out  = dec_q & last_q;

endmodule

@@ hdl/kbs_chk.sv @@
// Port-level checks for the keyed byte substitution unit, with bind
`include "keyed_byte_substitution_unit_defines.svh"

module kbs_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic                         req_type,
	input logic                         done,
	input logic [7:0]                   out_byte,
	input logic [31:0]                  final_key,
	input logic                         last_out
);
	import kbs_pkg::*;

	`KBS_ASSERT_NXT(a_dec_strobe, start && !busy && req_type == REQ_DECODE, done)
	`KBS_ASSERT_NXT(a_bld_busy, start && !busy && req_type == REQ_BUILD, busy)
	`KBS_ASSERT_IMP(a_bld_done, $fell(busy), done)
	`KBS_ASSERT_IMP(a_bld_word, done && final_key != 32'h0, !last_out && out_byte == 8'h00)

endmodule

bind keyed_byte_substitution_unit kbs_chk u_kbs_chk (.*);

@@ verif/kbs_decode_checker.sv @@
// Checker for the keyed byte substitution unit: predicts each result word and compares it
module kbs_decode_checker
	import kbs_pkg::*;
#(
	parameter int ROUNDS = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [31:0]          cfg_data,
	input  logic                 start,
	input  logic                 busy,
	input  logic                 req_type,
	input  logic [7:0]           in_byte,
	input  logic                 last_in,
	input  logic                 done,
	input  logic [7:0]           out_byte,
	input  logic [31:0]          final_key,
	input  logic                 last_out,
	output int                   errors,
	output int                   outstanding
);

	typedef struct packed {
		logic [7:0]  out_byte;
		logic [31:0] final_key;
		logic        last_out;
	} sub_word_t;

	logic [31:0] init_key_q;
	logic [31:0] seed_q;
	logic [7:0]  xor_key_q;
	logic [7:0]  sub_tab [256];
	sub_word_t   expected_words [$];
	int          error_count = 0;
	int          waiting = 0;

	assign errors      = error_count;
	assign outstanding = waiting;

	task automatic report_error(input string msg);
		$display("%0t kbs: %s", $time, msg);
		error_count++;
	endtask

	// identity fill, then keyed swap rounds; returns the key left over
	function automatic logic [31:0] permute_table(input logic [31:0] key_in,
			input logic [31:0] sd);
		logic [31:0] k;
		logic [7:0]  a;
		logic [7:0]  b;
		logic [7:0]  t;
		k = key_in;
		for (int i = 0; i < 256; i++)
			sub_tab[i] = 8'(i);
		for (int r = 0; r < ROUNDS; r++) begin
			a = k[23:16];
			b = k[7:0];
			t = sub_tab[a];
			sub_tab[a] = sub_tab[b];
			sub_tab[b] = t;
			a = k[15:8];
			b = k[31:24];
			t = sub_tab[a];
			sub_tab[a] = sub_tab[b];
			sub_tab[b] = t;
			k = sd + KEY_MULT * {k[1:0], k[31:2]};
		end
		return k;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sub_word_t want;
		sub_word_t got;
		if (!arst_n) begin
			init_key_q = '0;
			seed_q     = '0;
			xor_key_q  = '0;
			for (int i = 0; i < 256; i++)
				sub_tab[i] = '0;
			expected_words.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_INIT_KEY: init_key_q = cfg_data;
					CFG_SEED:     seed_q     = cfg_data;
					CFG_XOR_KEY:  xor_key_q  = cfg_data[7:0];
					default:      ;
				endcase
			end
			if (start && !busy) begin
				if (req_type == REQ_BUILD)
					want = '{8'h00, permute_table(init_key_q, seed_q), 1'b0};
				else
					want = '{sub_tab[xor_key_q ^ in_byte], 32'h0, last_in};
				expected_words.push_back(want);
			end
			if (done) begin
				got = '{out_byte, final_key, last_out};
				if (expected_words.size() == 0) begin
					report_error($sformatf("result word with none pending: %h", got));
				end else begin
					want = expected_words.pop_front();
					if (got.out_byte !== want.out_byte)
						report_error($sformatf("out_byte %h, want %h",
							got.out_byte, want.out_byte));
					if (got.final_key !== want.final_key)
						report_error($sformatf("final_key %h, want %h",
							got.final_key, want.final_key));
					if (got.last_out !== want.last_out)
						report_error($sformatf("last_out %b, want %b",
							got.last_out, want.last_out));
				end
			end
		end
		waiting = expected_words.size();
	end

endmodule

@@ verif/keyed_byte_substitution_unit_tb.sv @@
// Testbench top for the keyed byte substitution unit: stimulus, watchdog and verdict
module keyed_byte_substitution_unit_tb;
	import kbs_pkg::*;

	localparam int ROUNDS      = 256;
	localparam int STALL_LIMIT = 8 * 6 * ROUNDS + 1000;
	localparam int PHASES      = 10;
	localparam int PHASE_WORDS = 170;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 cfg_we   = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx  = '0;
	logic [31:0]          cfg_data = '0;
	logic                 start    = 1'b0;
	logic                 req_type = REQ_DECODE;
	logic [7:0]           in_byte  = '0;
	logic                 last_in  = 1'b0;
	logic                 busy;
	logic                 done;
	logic [7:0]           out_byte;
	logic [31:0]          final_key;
	logic                 last_out;
	int                   fail_count;
	int                   pending;
	int                   quiet_cycles = 0;
	bit                   gaps_on = 1'b1;

	always #6 clk = ~clk;

	keyed_byte_substitution_unit #(.ROUNDS(ROUNDS)) DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.start(start), .busy(busy),
		.req_type(req_type), .in_byte(in_byte), .last_in(last_in),
		.done(done), .out_byte(out_byte), .final_key(final_key), .last_out(last_out)
	);

	kbs_decode_checker #(.ROUNDS(ROUNDS)) checker_i (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.start(start), .busy(busy),
		.req_type(req_type), .in_byte(in_byte), .last_in(last_in),
		.done(done), .out_byte(out_byte), .final_key(final_key), .last_out(last_out),
		.errors(fail_count), .outstanding(pending)
	);

	// watchdog: cycles with no word moving on either side
	always @(posedge clk) begin
		if ((start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("keyed_byte_substitution_unit_tb: errors");
			$finish;
		end
	end

	// caller lowers cfg_we once the last write is done
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	task automatic send(input logic req, input logic [7:0] data, input logic last);
		start    <= 1'b1;
		req_type <= req;
		in_byte  <= data;
		last_in  <= last;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic pause(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// hold off until every result word is back, then let the block settle
	task automatic drain();
		start <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		logic [31:0] key_v;
		logic [31:0] seed_v;
		logic [31:0] xor_v;
		logic        req;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unmapped index must be ignored
		write_reg(CFG_UNUSED, $urandom);
		cfg_we <= 1'b0;
		// table still zero before any build
		send(REQ_DECODE, 8'h00, 1'b0);
		send(REQ_DECODE, 8'hFF, 1'b1);
		send(REQ_DECODE, 8'h5A, 1'b0);
		// zero key and seed: each swap is an entry with itself
		send(REQ_BUILD, 8'h00, 1'b0);
		send(REQ_DECODE, 8'h00, 1'b1);
		send(REQ_DECODE, 8'hFF, 1'b0);
		send(REQ_DECODE, 8'h80, 1'b1);
		drain();

		write_reg(CFG_INIT_KEY, 32'hFFFF_FFFF);
		write_reg(CFG_SEED, 32'hFFFF_FFFF);
		write_reg(CFG_XOR_KEY, 32'hFFFF_FFFF);
		cfg_we <= 1'b0;
		send(REQ_BUILD, 8'hFF, 1'b1);
		send(REQ_DECODE, 8'h00, 1'b0);
		send(REQ_DECODE, 8'hFF, 1'b1);
		send(REQ_DECODE, 8'h7F, 1'b0);
		send(REQ_BUILD, 8'h00, 1'b0);
		send(REQ_DECODE, 8'h80, 1'b1);
		drain();

		// upper bits of xor key are dropped
		write_reg(CFG_XOR_KEY, 32'hABCD_EF5A);
		cfg_we <= 1'b0;
		send(REQ_DECODE, 8'h5A, 1'b0);
		send(REQ_DECODE, 8'hA5, 1'b1);
		send(REQ_DECODE, 8'h01, 1'b0);
		drain();

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin
					key_v  = 32'h0;
					seed_v = 32'hFFFF_FFFF;
					xor_v  = 32'h0;
				end
				1: begin
					key_v  = 32'hFFFF_FFFF;
					seed_v = 32'h0;
					xor_v  = 32'hFF;
				end
				default: begin
					key_v  = $urandom;
					seed_v = $urandom;
					xor_v  = $urandom;
				end
			endcase
			gaps_on = (p < PHASES - 2);
			write_reg(CFG_INIT_KEY, key_v);
			write_reg(CFG_SEED, seed_v);
			if ($urandom_range(0, 3) == 0)
				write_reg(CFG_UNUSED, $urandom);
			write_reg(CFG_XOR_KEY, xor_v);
			cfg_we <= 1'b0;
			send(REQ_BUILD, 8'($urandom), 1'($urandom));
			for (int n = 0; n < PHASE_WORDS; n++) begin
				if (gaps_on && $urandom_range(0, 7) == 0)
					pause($urandom_range(1, 19));
				req = ($urandom_range(0, 59) == 0) ? REQ_BUILD : REQ_DECODE;
				send(req, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			end
			drain();
		end

		@(negedge clk);
		if (fail_count == 0)
			$display("keyed_byte_substitution_unit_tb: clean");
		else
			$display("keyed_byte_substitution_unit_tb: errors");
		$finish;
	end

endmodule
